>>> src/rvs_pkg.sv
`timescale 1ns / 1ps
// Shared types, opcodes and item codes for the RV32E subset step core.
package rvs_pkg;

    localparam int RVS_MEM_BYTES = 4096;

    // Item operation codes
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Instruction opcodes
    localparam logic [6:0] OPC_ADDI  = 7'b0010011;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_ADD   = 7'b0110011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;

    // funct3 codes
    localparam logic [2:0] F3_ZERO  = 3'd0;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;

    // funct7 code
    localparam logic [6:0] F7_ZERO = 7'd0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [3:0]  register_index;
    } rvs_cmd_t;

    typedef struct packed {
        logic [31:0] program_counter;
        logic        status;
        logic [31:0] register_value;
    } rvs_res_t;

    typedef enum logic [2:0] {
        PH_CLEAR,
        PH_IDLE,
        PH_DECODE,
        PH_EXEC,
        PH_LOAD
    } rvs_state_t;

    typedef enum logic [2:0] {
        K_ADDI,
        K_JALR,
        K_LW,
        K_LBU,
        K_SW,
        K_SB,
        K_ADD,
        K_LUI
    } rvs_kind_t;

    typedef struct packed {
        rvs_kind_t   kind;
        logic [3:0]  rd;
        logic [31:0] imm;
    } rvs_dec_t;

endpackage

>>> src/rv32e_subset_instruction_step.sv
`timescale 1ns / 1ps
// Top level of the RV32E subset step core: sequencer, decode, execute and memories.
//
//  channel | signals                     | moves
//  --------+-----------------------------+------------------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd   | one step item (execute, byte write, read)
//  res     | res_valid, res_stall, res   | pc, halt status and register value
//
//  Host items, reads and illegal or halted executes end in decode; addi, add, lui, jalr,
//  sw and sb end in execute (fetch, then register read); lw and lbu end in load (the extra
//  data read on the byte banks). The next item enters in the cycle the current one ends.
//  Reset: an async low reset starts a clearing pass that zeroes every row of the byte
//  banks; cmd_stall stays high during it.
//  Stalls: a finished item waits in its last phase while the result register is full
//  and stalled; the result register itself holds a transfer until it is taken.
module rv32e_subset_instruction_step #(
    parameter int MEM_BYTES = rvs_pkg::RVS_MEM_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  rvs_pkg::rvs_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output rvs_pkg::rvs_res_t res
);

    import rvs_pkg::*;

    // MEM_BYTES is a power of two; byte address bit [1:0] picks one of four byte banks,
    // the rest picks the row, so an unaligned or wrapping word touches each bank once.
    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = MEM_BYTES / 4;
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    // Row of the bank that holds one of the four bytes starting at byte address a.
    function automatic logic [RW-1:0] bank_row(input logic [AW-1:0] a, input logic [1:0] b);
        logic [1:0]    ofs;
        logic [AW-1:0] s;
        ofs = b - a[1:0];
        s   = a + {{(AW-2){1'b0}}, ofs};
        return s[AW-1:2];
    endfunction

    // Sequencer and item state
    rvs_state_t    state_reg;
    rvs_state_t    state_next;
    logic [RW-1:0] clr_cnt_reg;
    logic [31:0]   pc_reg;
    logic          halted_reg;
    logic [15:0]   rf_valid_reg;
    logic [1:0]    op_reg;
    logic [AW-1:0] haddr_reg;
    logic [7:0]    hbyte_reg;
    rvs_dec_t      dec_reg;
    logic [1:0]    lo_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic          res_valid_reg;
    rvs_res_t      res_reg;

    // Byte bank ports
    logic [3:0]    bank_we;
    logic [RW-1:0] bank_waddr [4];
    logic [7:0]    bank_wdata [4];
    logic [3:0]    bank_re;
    logic [RW-1:0] bank_raddr [4];
    logic [7:0]    bank_rdata [4];

    // Register file ports (two copies, written alike, one per source operand)
    logic          rf_we;
    logic [3:0]    rf_waddr;
    logic [31:0]   rf_wdata;
    logic          rf_re_a;
    logic [3:0]    rf_raddr_a;
    logic [31:0]   rf_rdata_a;
    logic          rf_re_b;
    logic [3:0]    rf_raddr_b;
    logic [31:0]   rf_rdata_b;

    // Decode and execute
    logic [31:0]   ins;
    logic [31:0]   ld_word;
    logic [31:0]   imm_i;
    logic [31:0]   imm_s;
    logic [31:0]   imm_u;
    logic          legal;
    rvs_dec_t      dec_next;
    logic          is_load;
    logic          is_store;
    logic [31:0]   rs1_val;
    logic [31:0]   rs2_val;
    logic [31:0]   opb;
    logic [31:0]   sum;
    logic [31:0]   pc_plus4;
    logic          pc_wr;
    logic [31:0]   pc_new;
    logic [31:0]   pc_cur;
    logic          halt_set;
    logic [31:0]   rv;
    logic [31:0]   host_wide;
    logic [AW-1:0] host_addr;

    // Handshake
    logic          accept;
    logic          fin;
    logic          res_free;
    logic          done;
    logic          fire;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        rvs_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[gb]),
            .waddr (bank_waddr[gb]),
            .wdata (bank_wdata[gb]),
            .re    (bank_re[gb]),
            .raddr (bank_raddr[gb]),
            .rdata (bank_rdata[gb])
        );
    end

    rvs_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (rf_re_a),
        .raddr (rf_raddr_a),
        .rdata (rf_rdata_a)
    );

    rvs_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (rf_re_b),
        .raddr (rf_raddr_b),
        .rdata (rf_rdata_b)
    );

    // ---------------------------------------------------------------
    // Fetch assembly and decode (decode phase)
    // ---------------------------------------------------------------
    always_comb
    begin
        // Rotate bank outputs back into byte order: byte i sits in bank (base + i).
        for (int i = 0; i < 4; i++)
        begin
            ins[8*i +: 8]     = bank_rdata[2'(pc_reg[1:0] + 2'(i))];
            ld_word[8*i +: 8] = bank_rdata[2'(lo_reg + 2'(i))];
        end

        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_u = {ins[31:12], 12'd0};

        dec_next.kind = K_ADDI;
        dec_next.rd   = ins[10:7];
        dec_next.imm  = imm_i;
        legal         = 1'b0;

        // Register fields of 16 or more are illegal in RV32E: bit 4 of each field.
        case (ins[6:0])
            OPC_ADDI:
            begin
                dec_next.kind = K_ADDI;
                legal = (ins[14:12] == F3_ZERO) && !ins[11] && !ins[19];
            end
            OPC_JALR:
            begin
                dec_next.kind = K_JALR;
                legal = (ins[14:12] == F3_ZERO) && !ins[11] && !ins[19];
            end
            OPC_LOAD:
            begin
                dec_next.kind = (ins[14:12] == F3_WORD) ? K_LW : K_LBU;
                legal = (ins[14:12] inside {F3_WORD, F3_BYTEU}) && !ins[11] && !ins[19];
            end
            OPC_STORE:
            begin
                dec_next.kind = (ins[14:12] == F3_WORD) ? K_SW : K_SB;
                dec_next.imm  = imm_s;
                legal = (ins[14:12] inside {F3_ZERO, F3_WORD}) && !ins[19] && !ins[24];
            end
            OPC_ADD:
            begin
                dec_next.kind = K_ADD;
                legal = (ins[14:12] == F3_ZERO) && (ins[31:25] == F7_ZERO)
                        && !ins[11] && !ins[19] && !ins[24];
            end
            OPC_LUI:
            begin
                dec_next.kind = K_LUI;
                dec_next.imm  = imm_u;
                legal = !ins[11];
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign is_load  = (dec_reg.kind == K_LW) || (dec_reg.kind == K_LBU);
    assign is_store = (dec_reg.kind == K_SW) || (dec_reg.kind == K_SB);

    always_comb
    begin
        case (state_reg)
            PH_DECODE: fin = (op_reg != OP_EXEC) || halted_reg || !legal;
            PH_EXEC:   fin = !is_load;
            PH_LOAD:   fin = 1'b1;
            default:   fin = 1'b0;
        endcase
    end

    assign res_free  = !res_valid_reg || !res_stall;
    assign done      = fin && res_free;
    assign fire      = !fin || res_free;
    // Take the next item when idle or in the cycle the current one hands off its result.
    assign cmd_stall = !((state_reg == PH_IDLE) || done);
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PH_CLEAR:
            begin
                if (clr_cnt_reg == ROW_LAST)
                begin
                    state_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                if (accept)
                begin
                    state_next = PH_DECODE;
                end
            end
            PH_DECODE:
            begin
                if (!fin)
                begin
                    state_next = PH_EXEC;
                end
                else if (done)
                begin
                    state_next = accept ? PH_DECODE : PH_IDLE;
                end
            end
            PH_EXEC:
            begin
                if (!fin)
                begin
                    state_next = PH_LOAD;
                end
                else if (done)
                begin
                    state_next = accept ? PH_DECODE : PH_IDLE;
                end
            end
            PH_LOAD:
            begin
                if (done)
                begin
                    state_next = accept ? PH_DECODE : PH_IDLE;
                end
            end
            default:
            begin
                state_next = PH_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Execute
    // ---------------------------------------------------------------
    always_comb
    begin
        rs1_val  = v1_reg ? rf_rdata_a : 32'd0;
        rs2_val  = v2_reg ? rf_rdata_b : 32'd0;
        opb      = (dec_reg.kind == K_ADD) ? rs2_val : dec_reg.imm;
        sum      = rs1_val + opb;
        pc_plus4 = pc_reg + 32'd4;

        // Loads advance pc as they leave the execute phase; the result picks it up later.
        pc_wr  = (state_reg == PH_EXEC) && fire;
        pc_new = (dec_reg.kind == K_JALR) ? {sum[31:1], 1'b0} : pc_plus4;
        // Forward the new pc to the fetch of an item taken in the same cycle.
        pc_cur = pc_wr ? pc_new : pc_reg;

        halt_set = (state_reg == PH_DECODE) && done && (op_reg == OP_EXEC)
                   && !halted_reg && !legal;

        rv = ((state_reg == PH_DECODE) && (op_reg == OP_READ)) ? rs1_val : 32'd0;

        rf_waddr = dec_reg.rd;
        if (state_reg == PH_LOAD)
        begin
            rf_we    = done && (dec_reg.rd != 4'd0);
            rf_wdata = (dec_reg.kind == K_LBU) ? {24'd0, ld_word[7:0]} : ld_word;
        end
        else
        begin
            rf_we = (state_reg == PH_EXEC) && fire && !is_load && !is_store
                    && (dec_reg.rd != 4'd0);
            case (dec_reg.kind)
                K_JALR:  rf_wdata = pc_plus4;
                K_LUI:   rf_wdata = dec_reg.imm;
                default: rf_wdata = sum;
            endcase
        end

        // Operand reads go out in decode for a legal instruction; a register read item
        // uses port A in its accept cycle. Both never fall in the same cycle.
        rf_re_a    = ((state_reg == PH_DECODE) && !fin) || (accept && (cmd.operation == OP_READ));
        rf_raddr_a = ((state_reg == PH_DECODE) && !fin) ? ins[18:15] : cmd.register_index;
        rf_re_b    = (state_reg == PH_DECODE) && !fin;
        rf_raddr_b = ins[23:20];
    end

    // ---------------------------------------------------------------
    // Byte bank access
    // ---------------------------------------------------------------
    assign host_wide = {20'd0, cmd.byte_address};
    assign host_addr = host_wide[AW-1:0];

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = clr_cnt_reg;
            bank_wdata[b] = 8'd0;
            if (state_reg == PH_CLEAR)
            begin
                bank_we[b] = 1'b1;
            end
            else if ((state_reg == PH_DECODE) && (op_reg == OP_WRITE) && done
                     && (haddr_reg[1:0] == 2'(b)))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = haddr_reg[AW-1:2];
                bank_wdata[b] = hbyte_reg;
            end
            else if ((state_reg == PH_EXEC) && done
                     && ((dec_reg.kind == K_SW)
                         || ((dec_reg.kind == K_SB) && (sum[1:0] == 2'(b)))))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = bank_row(sum[AW-1:0], 2'(b));
                bank_wdata[b] = rs2_val[8*(2'(2'(b) - sum[1:0])) +: 8];
            end

            // Data reads of a load never meet a fetch: no item is taken in that cycle.
            if ((state_reg == PH_EXEC) && is_load)
            begin
                bank_re[b]    = 1'b1;
                bank_raddr[b] = bank_row(sum[AW-1:0], 2'(b));
            end
            else
            begin
                bank_re[b]    = accept && (cmd.operation == OP_EXEC);
                bank_raddr[b] = bank_row(pc_cur[AW-1:0], 2'(b));
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= 32'd0;
            halted_reg    <= 1'b0;
            rf_valid_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == PH_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
            end
            if (pc_wr)
            begin
                pc_reg <= pc_new;
            end
            if (halt_set)
            begin
                halted_reg <= 1'b1;
            end
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.operation;
            haddr_reg <= host_addr;
            hbyte_reg <= cmd.byte_value;
        end
        if ((state_reg == PH_DECODE) && !fin)
        begin
            dec_reg <= dec_next;
        end
        if ((state_reg == PH_EXEC) && is_load)
        begin
            lo_reg <= sum[1:0];
        end
        // Never-written registers read as zero; a write in the same cycle counts.
        if (rf_re_a)
        begin
            v1_reg <= rf_valid_reg[rf_raddr_a] || (rf_we && (rf_waddr == rf_raddr_a));
        end
        if (rf_re_b)
        begin
            v2_reg <= rf_valid_reg[rf_raddr_b] || (rf_we && (rf_waddr == rf_raddr_b));
        end
        if (done)
        begin
            res_reg.program_counter <= pc_cur;
            res_reg.status          <= halted_reg || halt_set;
            res_reg.register_value  <= rv;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_CLEAR) |-> cmd_stall)
        else $error("item taken during the clearing pass");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == PH_DECODE))
        else $error("accepted item did not enter decode");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (rf_waddr != 4'd0) && ((state_reg == PH_EXEC) || (state_reg == PH_LOAD)))
        else $error("register write to x0 or outside execute and load");

endmodule

>>> src/rvs_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, one registered read port, write-first on a collision.
module rvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read data until the next read; pass a same-cycle write through.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata <= wdata;
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule
